// ----- sv/rop_pkg.sv -----
// ----------------------------------------------------------------------------
// rop_pkg
// Types, codes and sizes shared by the rectangle occupancy placer.
// ----------------------------------------------------------------------------
`default_nettype none

package rop_pkg;

	localparam int DEF_MAX_ROWS = 256;
	localparam int DEF_MAX_COLS = 256;

	localparam int CFG_W     = 9;   // grid size register width
	localparam int POS_W     = 12;  // start row / column width
	localparam int SIZE_W    = 8;   // rectangle height / width
	localparam int PROW_W    = 13;  // reported row width
	localparam int WORD_BITS = 64;  // cells per memory word
	localparam int WOFF_W    = 6;   // bit offset inside a word
	localparam int SWORD_W   = CFG_W - WOFF_W;  // word index inside a row
	localparam int CFG_MAX   = 511;             // largest value a size register holds

	typedef enum logic {
		OP_PLACE = 1'b0,
		OP_CLEAR = 1'b1
	} op_e;

	typedef enum logic [0:0] {
		REG_GRID_ROWS = 1'b0,
		REG_GRID_COLS = 1'b1
	} reg_idx_e;

	typedef struct packed {
		op_e               operation;
		logic [POS_W-1:0]  start_row;
		logic [POS_W-1:0]  start_col;
		logic [SIZE_W-1:0] rect_height;
		logic [SIZE_W-1:0] rect_width;
	} item_t;

	typedef struct packed {
		logic [PROW_W-1:0] placed_row;
		logic              cells_marked;
	} result_t;

	typedef struct packed {
		reg_idx_e         reg_index;
		logic [CFG_W-1:0] wdata;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SETUP,
		ST_ROUND,
		ST_TEST_RD,
		ST_TEST_CHK,
		ST_MARK_RD,
		ST_MARK_WR,
		ST_DONE
	} eng_state_t;

	// column window of the rectangle, handed to the mask unit
	typedef struct packed {
		logic [SWORD_W-1:0] word;
		logic [SWORD_W-1:0] first_word;
		logic [WOFF_W-1:0]  first_off;
		logic [SWORD_W-1:0] last_word;
		logic [WOFF_W-1:0]  last_off;
	} mask_req_t;

	typedef struct packed {
		logic             start;
		item_t            item;
		logic             clr_req;
		logic [CFG_W-1:0] rows;
		logic [CFG_W-1:0] cols;
		logic             res_take;
	} ctrl_t;

	typedef struct packed {
		logic    idle;
		logic    done;
		result_t res;
	} status_t;

endpackage

`default_nettype wire

// ----- sv/rop_stream_if.sv -----
// ----------------------------------------------------------------------------
// rop_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface rop_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/rect_occupancy_placer.sv -----
// ----------------------------------------------------------------------------
// rect_occupancy_placer
// Bit-per-cell occupancy grid with rectangle placement and downward search.
// ----------------------------------------------------------------------------
// One item is worked at a time by a sequencer around a single 64-bit memory
// port and one mask/compare unit. A place item runs a setup step, then
// search rounds that test the grid words of the window one by one (a round
// stops at the first occupied word), and then a read and a write for each
// word marked; a word is 64 columns of one row of the clipped rectangle. A
// clear item zeroes grid_rows * ceil(grid_cols / 64) words. Writing a size
// register starts the same clearing sweep over the new grid size, and after
// reset a sweep over the 1x1 grid runs; no item is taken during a sweep,
// while register writes are always taken. A finished result sits in an
// output register, so the next item is taken while it waits.
`default_nettype none

module rect_occupancy_placer #(
	parameter int MAX_ROWS = rop_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = rop_pkg::DEF_MAX_COLS
) (
	input  logic         clk,
	input  logic         arst_n,
	rop_stream_if.sink   in_item,
	rop_stream_if.source out_result,
	rop_stream_if.sink   cfg
);
	import rop_pkg::*;

	logic [CFG_W-1:0] grid_rows_q;
	logic [CFG_W-1:0] grid_cols_q;
	logic             cfg_wr;
	logic [CFG_W-1:0] sat_rows;
	logic [CFG_W-1:0] sat_cols;

	logic    out_valid_q;
	result_t out_data_q;
	logic    take;

	ctrl_t   ctrl;
	status_t status;

	rop_engine #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.status (status)
	);

	// sizes saturate at the grid built in
	always_comb begin
		cfg_wr   = cfg.valid && cfg.ready;
		sat_rows = ({4'b0, cfg.data.wdata} > 13'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : cfg.data.wdata;
		sat_cols = ({4'b0, cfg.data.wdata} > 13'(MAX_COLS)) ? CFG_W'(MAX_COLS) : cfg.data.wdata;
		take     = status.done && (!out_valid_q || out_result.ready);

		ctrl.start    = in_item.valid && in_item.ready;
		ctrl.item     = in_item.data;
		ctrl.clr_req  = cfg_wr;
		ctrl.rows     = grid_rows_q;
		ctrl.cols     = grid_cols_q;
		ctrl.res_take = take;
	end

	assign cfg.ready        = 1'b1;
	assign in_item.ready    = status.idle;
	assign out_result.valid = out_valid_q;
	assign out_result.data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= 9'd1;
			grid_cols_q <= 9'd1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (cfg.data.reg_index)
					REG_GRID_ROWS: grid_rows_q <= sat_rows;
					REG_GRID_COLS: grid_cols_q <= sat_cols;
					default: ;
				endcase
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (out_result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_data_q <= status.res;
		end
	end

endmodule

`default_nettype wire

// ----- sv/rop_mask_unit.sv -----
// ----------------------------------------------------------------------------
// rop_mask_unit
// Builds the column mask of one grid word and tests / merges it with the word.
// ----------------------------------------------------------------------------
`default_nettype none

module rop_mask_unit (
	input  rop_pkg::mask_req_t                 req,
	input  logic [rop_pkg::WORD_BITS-1:0]      rdata,
	output logic                               hit,
	output logic [rop_pkg::WORD_BITS-1:0]      merged
);
	import rop_pkg::*;

	logic [WOFF_W-1:0]    lo_off;
	logic [WOFF_W-1:0]    hi_off;
	logic [WORD_BITS-1:0] mask;

	always_comb begin
		lo_off = (req.word == req.first_word) ? req.first_off : '0;
		hi_off = (req.word == req.last_word) ? req.last_off : '1;
		// bits lo_off..hi_off inclusive
		mask   = ({WORD_BITS{1'b1}} << lo_off) & ({WORD_BITS{1'b1}} >> (~hi_off));
		hit    = |(rdata & mask);
		merged = rdata | mask;
	end

endmodule

`default_nettype wire

// ----- sv/rop_engine.sv -----
// ----------------------------------------------------------------------------
// rop_engine
// Sequencer and occupancy memory: clearing sweep, downward search and marking.
// ----------------------------------------------------------------------------
`default_nettype none

module rop_engine #(
	parameter int MAX_ROWS = rop_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = rop_pkg::DEF_MAX_COLS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  rop_pkg::ctrl_t   ctrl,
	output rop_pkg::status_t status
);
	import rop_pkg::*;

	localparam int USED_ROWS = (MAX_ROWS < CFG_MAX) ? MAX_ROWS : CFG_MAX;
	localparam int USED_COLS = (MAX_COLS < CFG_MAX) ? MAX_COLS : CFG_MAX;
	localparam int COL_WORDS = (USED_COLS + WORD_BITS - 1) / WORD_BITS;
	localparam int DEPTH     = USED_ROWS * COL_WORDS;
	localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	eng_state_t state_q, state_d;

	logic [CFG_W-1:0]   scan_row_q, row_nx;
	logic [SWORD_W-1:0] scan_word_q, word_nx;
	logic               clr_item_q;

	logic [PROW_W-1:0]  row_q;
	logic [POS_W-1:0]   col_q;
	logic [SIZE_W-1:0]  h_q;
	logic [SIZE_W-1:0]  w_q;
	logic [SWORD_W-1:0] first_word_q;
	logic [WOFF_W-1:0]  first_off_q;
	logic [SWORD_W-1:0] last_word_q;
	logic [WOFF_W-1:0]  last_off_q;
	logic [CFG_W-1:0]   row_last_q;
	logic               marked_q;

	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] rd_data_q;
	logic [ADDR_W-1:0]    addr;
	logic                 mem_we;
	logic                 mem_re;
	logic [WORD_BITS-1:0] mem_wdata;

	logic [CFG_W-1:0]   cols_m1;
	logic [CFG_W-1:0]   rows_m1;
	logic [SWORD_W-1:0] clr_last_word;
	logic               grid_empty;
	logic               sweep_last;
	logic               area_last;
	logic               trivial;
	logic               row_off;
	logic [PROW_W-1:0]  col_sum;
	logic [CFG_W-1:0]   col_last;
	logic [PROW_W-1:0]  row_sum;
	logic [CFG_W-1:0]   row_last;
	logic [SWORD_W-1:0] word_base;
	logic [SWORD_W-1:0] word_end;

	mask_req_t            mreq;
	logic                 hit;
	logic [WORD_BITS-1:0] merged;

	rop_mask_unit u_mask (
		.req    (mreq),
		.rdata  (rd_data_q),
		.hit    (hit),
		.merged (merged)
	);

	// bounds and window arithmetic
	always_comb begin
		cols_m1       = ctrl.cols - 9'd1;
		rows_m1       = ctrl.rows - 9'd1;
		clr_last_word = cols_m1[CFG_W-1:WOFF_W];
		grid_empty    = (ctrl.rows == '0) || (ctrl.cols == '0);
		sweep_last    = (scan_word_q == clr_last_word) && (scan_row_q == rows_m1);
		area_last     = (scan_word_q == last_word_q) && (scan_row_q == row_last_q);

		trivial = ({1'b0, col_q} >= {4'b0, ctrl.cols}) || (h_q == '0) || (w_q == '0);
		col_sum = {1'b0, col_q} + {5'b0, w_q};
		col_last = ((col_sum > {4'b0, ctrl.cols}) ? ctrl.cols : col_sum[CFG_W-1:0]) - 9'd1;

		row_off  = row_q >= {4'b0, ctrl.rows};
		row_sum  = row_q + {5'b0, h_q};
		row_last = ((row_sum > {4'b0, ctrl.rows}) ? ctrl.rows : row_sum[CFG_W-1:0]) - 9'd1;

		// the clearing sweep covers whole rows, the search and the marking only the window
		word_base = (state_q == ST_CLEAR) ? '0 : first_word_q;
		word_end  = (state_q == ST_CLEAR) ? clr_last_word : last_word_q;
		if (scan_word_q == word_end) begin
			word_nx = word_base;
			row_nx  = scan_row_q + 9'd1;
		end else begin
			word_nx = scan_word_q + 3'd1;
			row_nx  = scan_row_q;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		if (ctrl.clr_req) begin
			state_d = ST_CLEAR;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ctrl.start) begin
						state_d = (ctrl.item.operation == OP_CLEAR) ? ST_CLEAR : ST_SETUP;
					end
				end
				ST_CLEAR: begin
					if (grid_empty || sweep_last) begin
						state_d = clr_item_q ? ST_DONE : ST_IDLE;
					end
				end
				ST_SETUP:    state_d = trivial ? ST_DONE : ST_ROUND;
				ST_ROUND:    state_d = row_off ? ST_DONE : ST_TEST_RD;
				ST_TEST_RD:  state_d = ST_TEST_CHK;
				ST_TEST_CHK: begin
					if (hit) begin
						state_d = ST_ROUND;
					end else if (area_last) begin
						state_d = ST_MARK_RD;
					end else begin
						state_d = ST_TEST_RD;
					end
				end
				ST_MARK_RD:  state_d = ST_MARK_WR;
				ST_MARK_WR:  state_d = area_last ? ST_DONE : ST_MARK_RD;
				ST_DONE: begin
					if (ctrl.res_take) begin
						state_d = ST_IDLE;
					end
				end
				default:     state_d = ST_IDLE;
			endcase
		end
	end

	// outputs and memory controls
	always_comb begin
		mreq.word       = scan_word_q;
		mreq.first_word = first_word_q;
		mreq.first_off  = first_off_q;
		mreq.last_word  = last_word_q;
		mreq.last_off   = last_off_q;

		addr      = ADDR_W'(32'(scan_row_q) * 32'(COL_WORDS) + 32'(scan_word_q));
		mem_we    = ((state_q == ST_CLEAR) && !grid_empty) || (state_q == ST_MARK_WR);
		mem_re    = (state_q == ST_TEST_RD) || (state_q == ST_MARK_RD);
		mem_wdata = (state_q == ST_CLEAR) ? '0 : merged;

		status.idle             = state_q == ST_IDLE;
		status.done             = state_q == ST_DONE;
		status.res.placed_row   = row_q;
		status.res.cells_marked = marked_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			scan_row_q  <= '0;
			scan_word_q <= '0;
			clr_item_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.clr_req) begin
				scan_row_q  <= '0;
				scan_word_q <= '0;
				clr_item_q  <= 1'b0;
			end else begin
				case (state_q)
					ST_IDLE: begin
						if (ctrl.start) begin
							scan_row_q  <= '0;
							scan_word_q <= '0;
							clr_item_q  <= ctrl.item.operation == OP_CLEAR;
						end
					end
					ST_CLEAR: begin
						scan_row_q  <= row_nx;
						scan_word_q <= word_nx;
					end
					ST_ROUND: begin
						scan_row_q  <= row_q[CFG_W-1:0];
						scan_word_q <= first_word_q;
					end
					ST_TEST_CHK: begin
						if (!hit) begin
							if (area_last) begin
								// free: go back to the top of the window to mark it
								scan_row_q  <= row_q[CFG_W-1:0];
								scan_word_q <= first_word_q;
							end else begin
								scan_row_q  <= row_nx;
								scan_word_q <= word_nx;
							end
						end
					end
					ST_MARK_WR: begin
						scan_row_q  <= row_nx;
						scan_word_q <= word_nx;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (ctrl.start) begin
					row_q    <= (ctrl.item.operation == OP_CLEAR) ? '0
					            : {1'b0, ctrl.item.start_row};
					col_q    <= ctrl.item.start_col;
					h_q      <= ctrl.item.rect_height;
					w_q      <= ctrl.item.rect_width;
					marked_q <= 1'b0;
				end
			end
			ST_SETUP: begin
				first_word_q <= col_q[CFG_W-1:WOFF_W];
				first_off_q  <= col_q[WOFF_W-1:0];
				last_word_q  <= col_last[CFG_W-1:WOFF_W];
				last_off_q   <= col_last[WOFF_W-1:0];
			end
			ST_ROUND:    row_last_q <= row_last;
			ST_TEST_CHK: begin
				if (hit) begin
					row_q <= row_sum;
				end
			end
			ST_MARK_WR:  marked_q <= 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[addr];
		end
	end

endmodule

`default_nettype wire

// ----- sv/rop_checker.sv -----
// ----------------------------------------------------------------------------
// rop_checker
// Port-level checks of the rectangle occupancy placer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rop_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input rop_pkg::result_t out_data
);
	import rop_pkg::*;

	// one item at a time: taking a beat closes the input
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input still ready right after a beat was taken");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result beat changed or dropped");

	// marking needs a top row on the grid
	a_marked_on_grid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.cells_marked |-> out_data.placed_row < 13'(CFG_MAX))
		else $error("cells marked for a row off the grid");

	// no result while an item is being taken on an idle block with nothing pending
	a_no_result_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result appeared one cycle after the item was taken");

endmodule

bind rect_occupancy_placer rop_checker u_rop_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_item.valid),
	.in_ready  (in_item.ready),
	.out_valid (out_result.valid),
	.out_ready (out_result.ready),
	.out_data  (out_result.data)
);

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rect_occupancy_placer. Place and clear beats are
// pushed through bursty valid/ready traffic into the block. Each accepted
// beat is run through a bit-per-cell grid predictor that does the same
// downward search. Every result beat is compared with the oldest prediction.
// Grid sizes are rewritten between phases, covering zero and oversize values.
// ----------------------------------------------------------------------------

module tb;
	import rop_pkg::*;

	localparam int ROWS_CAP       = DEF_MAX_ROWS;
	localparam int COLS_CAP       = DEF_MAX_COLS;
	localparam int WATCHDOG_LIMIT = 60000;
	localparam int RANDOM_ITEMS   = 1500;

	logic clk;
	logic arst_n;

	rop_stream_if #(.payload_t(item_t))   in_if ();
	rop_stream_if #(.payload_t(result_t)) out_if ();
	rop_stream_if #(.payload_t(cfg_t))    cfg_if ();

	rect_occupancy_placer u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_item    (in_if),
		.out_result (out_if),
		.cfg        (cfg_if)
	);

	// predicted grid and sizes
	logic [COLS_CAP-1:0] occ_grid [ROWS_CAP];
	int                  grid_rows_q;
	int                  grid_cols_q;

	item_t   items_to_send[$];
	result_t expected_placements[$];
	int      n_queued;
	int      n_accepted;
	int      errors;
	int      idle_cycles;

	int       burst_left;
	int       gap_left;
	int       stall_mode;
	bit [7:0] stall_tick;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void wipe_grid();
		for (int y = 0; y < ROWS_CAP; y++)
			occ_grid[y] = '0;
	endfunction

	function automatic bit rect_is_free(int row, int col, int h, int w);
		if (row >= grid_rows_q || col >= grid_cols_q)
			return 1'b1;
		for (int y = row; y < row + h && y < grid_rows_q; y++)
			for (int x = col; x < col + w && x < grid_cols_q; x++)
				if (occ_grid[y][x])
					return 1'b0;
		return 1'b1;
	endfunction

	function automatic bit mark_rect(int row, int col, int h, int w);
		bit any;
		any = 1'b0;
		if (row >= grid_rows_q || col >= grid_cols_q)
			return 1'b0;
		for (int y = row; y < row + h && y < grid_rows_q; y++)
			for (int x = col; x < col + w && x < grid_cols_q; x++) begin
				occ_grid[y][x] = 1'b1;
				any = 1'b1;
			end
		return any;
	endfunction

	function automatic result_t place_item(item_t it);
		result_t res;
		int      row;
		res = '0;
		if (it.operation == OP_CLEAR) begin
			wipe_grid();
			return res;
		end
		row = it.start_row;
		// a blocked test implies nonzero height, so the search always ends
		while (!rect_is_free(row, it.start_col, it.rect_height, it.rect_width))
			row += it.rect_height;
		res.cells_marked = mark_rect(row, it.start_col, it.rect_height, it.rect_width);
		res.placed_row   = PROW_W'(row);
		return res;
	endfunction

	function automatic void apply_reg(cfg_t w);
		int v;
		v = w.wdata;
		if (w.reg_index == REG_GRID_ROWS)
			grid_rows_q = (v > ROWS_CAP) ? ROWS_CAP : v;
		else
			grid_cols_q = (v > COLS_CAP) ? COLS_CAP : v;
		wipe_grid();
	endfunction

	function automatic item_t rand_item(int rows, int cols);
		item_t it;
		int    pick;
		pick           = $urandom_range(99);
		it.operation   = (pick < 4) ? OP_CLEAR : OP_PLACE;
		it.start_row   = POS_W'($urandom);
		it.start_col   = POS_W'($urandom);
		it.rect_height = SIZE_W'($urandom);
		it.rect_width  = SIZE_W'($urandom);
		if (pick >= 14) begin
			if ($urandom_range(1))
				it.start_row = POS_W'($urandom_range(rows / 4));
			else
				it.start_row = POS_W'($urandom_range(rows + 1));
			it.start_col   = POS_W'($urandom_range(cols + 1));
			it.rect_height = SIZE_W'($urandom_range(rows / 3 + 2));
			it.rect_width  = SIZE_W'($urandom_range(cols / 2 + 2));
		end
		return it;
	endfunction

	task automatic queue_item(item_t it);
		items_to_send.insert(items_to_send.size(), it);
		n_queued++;
	endtask

	task automatic send_place(int row, int col, int h, int w);
		item_t it;
		it.operation   = OP_PLACE;
		it.start_row   = POS_W'(row);
		it.start_col   = POS_W'(col);
		it.rect_height = SIZE_W'(h);
		it.rect_width  = SIZE_W'(w);
		queue_item(it);
	endtask

	task automatic send_clear(bit ones);
		item_t it;
		it           = ones ? '1 : '0;
		it.operation = OP_CLEAR;
		queue_item(it);
	endtask

	task automatic wait_drained();
		while (n_accepted != n_queued || expected_placements.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(reg_idx_e idx, int value);
		cfg_t w;
		w.reg_index = idx;
		w.wdata     = CFG_W'(value);
		wait_drained();
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= w;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
	endtask

	// item driver: bursts of beats separated by random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			in_if.valid <= 1'b0;
			in_if.data  <= '0;
			burst_left  = $urandom_range(32, 1);
			gap_left    = 0;
		end else begin
			if (in_if.valid && in_if.ready) begin
				expected_placements.insert(expected_placements.size(),
					place_item(in_if.data));
				n_accepted++;
			end
			if (!in_if.valid || in_if.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_if.valid <= 1'b0;
				end else if (items_to_send.size() > 0) begin
					in_if.valid <= 1'b1;
					in_if.data  <= items_to_send.pop_front();
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(40, 1);
						gap_left   = $urandom_range(1) ? 0 : $urandom_range(12, 1);
					end
				end else begin
					in_if.valid <= 1'b0;
				end
			end
		end
	end

	// result ready: stall pattern is picked anew whenever the low six bits of stall_tick are zero
	always @(posedge clk) begin
		if (!arst_n) begin
			out_if.ready <= 1'b0;
			stall_mode   <= 0;
			stall_tick   <= '0;
		end else begin
			stall_tick <= stall_tick + 8'd1;
			if (stall_tick[5:0] == 6'd0)
				stall_mode <= $urandom_range(3);
			case (stall_mode)
				0: out_if.ready <= 1'b1;
				1: out_if.ready <= ($urandom_range(3) != 0);
				2: out_if.ready <= (stall_tick[2:0] == 3'd5);
				default: out_if.ready <= $urandom_range(1);
			endcase
		end
	end

	// result checker and register tracking
	always @(posedge clk) begin : result_check
		result_t want;
		if (!arst_n) begin
			grid_rows_q = 1;
			grid_cols_q = 1;
			wipe_grid();
			idle_cycles = 0;
		end else begin
			if (cfg_if.valid && cfg_if.ready)
				apply_reg(cfg_if.data);
			if (out_if.valid && out_if.ready) begin
				if (expected_placements.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: result beat with none pending: row %0d marked %0d",
							$realtime, out_if.data.placed_row, out_if.data.cells_marked);
				end else begin
					want = expected_placements.pop_front();
					if (out_if.data.placed_row !== want.placed_row) begin
						errors++;
						if (errors <= 10)
							$display("%0t: placed_row expected %0d, got %0d",
								$realtime, want.placed_row, out_if.data.placed_row);
					end
					if (out_if.data.cells_marked !== want.cells_marked) begin
						errors++;
						if (errors <= 10)
							$display("%0t: cells_marked expected %0d, got %0d",
								$realtime, want.cells_marked, out_if.data.cells_marked);
					end
				end
			end
			if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
					|| (cfg_if.valid && cfg_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	initial begin : watchdog
		while (idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("rect_occupancy_placer: mismatch");
		$finish;
	end

	initial begin : stimulus
		int n_random;
		int rows_w;
		int cols_w;
		int n_phase;
		int pause_at;
		int sel;
		n_queued     = 0;
		n_accepted   = 0;
		errors       = 0;
		n_random     = 0;
		idle_cycles  = 0;
		cfg_if.valid <= 1'b0;
		cfg_if.data  <= '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// 1x1 grid after reset
		send_place(0, 0, 1, 1);
		send_place(0, 0, 1, 1);
		wait_drained();

		// directed beats on a grid straddling a word boundary
		write_reg(REG_GRID_ROWS, 16);
		write_reg(REG_GRID_COLS, 100);
		send_place(0, 0, 4, 70);
		send_place(0, 0, 4, 70);
		send_place(2, 60, 3, 10);
		send_place(0, 99, 255, 255);
		send_place(0, 99, 1, 1);
		send_place(3, 3, 0, 5);
		send_place(3, 3, 5, 0);
		send_place(4095, 0, 255, 255);
		send_place(0, 4095, 1, 1);
		send_place(0, 100, 1, 1);
		send_place(15, 0, 255, 255);
		send_clear(1'b1);
		send_place(0, 0, 255, 255);
		send_place(1, 1, 1, 1);
		send_clear(1'b0);
		wait_drained();

		// oversize registers saturate to the full grid
		write_reg(REG_GRID_ROWS, CFG_MAX);
		write_reg(REG_GRID_COLS, 300);
		send_place(0, 0, 255, 255);
		send_place(0, 0, 255, 255);
		send_place(255, 255, 1, 1);
		send_place(4095, 4095, 255, 255);
		send_clear(1'b0);

		// empty grids
		write_reg(REG_GRID_ROWS, 0);
		send_place(0, 0, 1, 1);
		write_reg(REG_GRID_ROWS, 5);
		write_reg(REG_GRID_COLS, 0);
		send_place(0, 0, 1, 1);
		write_reg(REG_GRID_ROWS, 1);
		write_reg(REG_GRID_COLS, 256);
		send_place(0, 0, 1, 255);
		send_place(0, 200, 3, 3);

		while (n_random < RANDOM_ITEMS) begin
			sel = $urandom_range(15);
			if (sel == 0) begin
				rows_w  = $urandom_range(CFG_MAX, 200);
				cols_w  = $urandom_range(CFG_MAX, 200);
				n_phase = 6;
			end else if (sel == 1) begin
				rows_w  = $urandom_range(1) ? 0 : $urandom_range(20, 1);
				cols_w  = (rows_w == 0) ? $urandom_range(80, 1) : 0;
				n_phase = 10;
			end else begin
				rows_w  = $urandom_range(48, 1);
				cols_w  = $urandom_range(200, 1);
				n_phase = $urandom_range(90, 20);
			end
			write_reg(REG_GRID_ROWS, rows_w);
			write_reg(REG_GRID_COLS, cols_w);
			pause_at = ($urandom_range(2) == 0) ? $urandom_range(n_phase - 1) : -1;
			for (int i = 0; i < n_phase; i++) begin
				// hold off until everything in flight has come back
				if (i == pause_at)
					wait_drained();
				queue_item(rand_item((rows_w > ROWS_CAP) ? ROWS_CAP : rows_w,
					(cols_w > COLS_CAP) ? COLS_CAP : cols_w));
			end
			n_random += n_phase;
		end

		wait_drained();
		repeat (40) @(posedge clk);
		if (errors == 0 && expected_placements.size() == 0)
			$display("rect_occupancy_placer: match");
		else
			$display("rect_occupancy_placer: mismatch");
		$finish;
	end

endmodule
